>>> rtl/stt_pkg.sv
// Package for the sparse triplet transpose block.
// Holds the beat payload types, the stored triplet type and the controller states.
// No dependencies.
package stt_pkg;

   typedef struct packed {
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] value;
      logic               has_entry;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_row;
      logic [3:0]         out_col;
      logic signed [31:0] out_value;
      logic               out_last;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] value;
   } triplet_type;

   typedef struct packed {
      logic shift;
      logic load;
   } chain_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   localparam int CSR_W = 5;

endpackage

>>> rtl/stt_cell.sv
// One cell of the triplet chain: holds a single stored triplet.
// Depends on stt_pkg for the triplet and chain control types.
module stt_cell
   import stt_pkg::*;
(
   input  logic           clock,
   input  chain_ctrl_type chain,
   input  triplet_type    d,
   output triplet_type    q
);

   triplet_type trip_ff;

   // The payload needs no reset: only cells below the fill count are ever emitted.
   always_ff @(posedge clock) begin
      if (chain.shift) begin
         trip_ff <= d;
      end
   end

   assign q = trip_ff;

endmodule

>>> rtl/stt_ctrl.sv
// Controller for the triplet chain: fill count, column scan and result staging.
// Depends on stt_pkg for payload, chain control and state types.
module stt_ctrl
   import stt_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int MAX_DIM     = 16
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_type          req_data,
   input  logic [CSR_W-1:0] num_cols,
   input  triplet_type      head,
   output logic             busy,
   output chain_ctrl_type   chain,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   localparam int CntW = $clog2(MAX_ENTRIES + 1);
   localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SumW = CntW + 1;
   localparam int DimW = $clog2(MAX_DIM + 1);
   localparam int CmpW = (DimW > CSR_W) ? DimW : CSR_W;

   state_type       state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            dropped_ff, dropped_in;
   logic [IdxW-1:0] step_ff, step_in;
   logic [DimW-1:0] colv_ff, colv_in;
   logic            pend_valid_ff, pend_valid_in;
   rsp_type         pend_ff, pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            store_full;
   logic            do_load;
   logic            do_drop;
   logic [CmpW-1:0] lim_wide;
   logic [DimW-1:0] lim;
   logic            abort;
   logic            scan_run;
   logic            step_end;
   logic            last_step;
   logic [SumW-1:0] pos_sum;
   logic            match;
   rsp_type         cand;

   assign accept     = start && (state_ff == ST_IDLE);
   assign store_full = (count_ff == CntW'(MAX_ENTRIES));
   assign do_load    = accept && req_data.has_entry && !store_full;
   assign do_drop    = accept && req_data.has_entry && store_full;

   assign lim_wide = (CmpW'(num_cols) > CmpW'(MAX_DIM)) ? CmpW'(MAX_DIM) : CmpW'(num_cols);
   assign lim      = lim_wide[DimW-1:0];

   assign abort     = (lim == '0) || (count_ff == '0);
   assign scan_run  = (state_ff == ST_SCAN) && !abort;
   assign step_end  = (step_ff == IdxW'(MAX_ENTRIES - 1));
   assign last_step = step_end && (colv_ff == lim - DimW'(1));

   // The chain rotates once per column; the oldest stored triplet reaches the
   // head when the step plus the fill count reaches the chain length.
   assign pos_sum = SumW'(step_ff) + SumW'(count_ff);
   assign match   = scan_run && (pos_sum >= SumW'(MAX_ENTRIES))
                    && (CmpW'(head.col) == CmpW'(colv_ff));

   always_comb begin
      cand.out_row   = head.col;
      cand.out_col   = head.row;
      cand.out_value = head.value;
      cand.out_last  = 1'b0;
      cand.overflow  = dropped_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.is_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (abort || last_step) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      step_in       = step_ff;
      colv_in       = colv_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            colv_in = '0;
            if (do_load) begin
               count_in = count_ff + CntW'(1);
            end
            if (do_drop) begin
               dropped_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (scan_run) begin
               step_in = step_end ? '0 : step_ff + IdxW'(1);
               if (step_end) begin
                  colv_in = colv_ff + DimW'(1);
               end
               if (match) begin
                  rsp_valid_in  = pend_valid_ff;
                  pend_in       = cand;
                  pend_valid_in = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            rsp_valid_in         = pend_valid_ff;
            rsp_data_in.out_last = 1'b1;
            pend_valid_in        = 1'b0;
            count_in             = '0;
            dropped_in           = 1'b0;
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         step_ff       <= '0;
         colv_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         step_ff       <= step_in;
         colv_ff       <= colv_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign chain.shift = do_load || scan_run;
   assign chain.load  = do_load;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

endmodule

>>> rtl/sparse_triplet_transpose_top.sv
// Sparse triplet transpose, top level: a chain of triplet cells and its controller.
// Load beats are taken back to back while idle; a beat marked last keeps busy high
// for a scan of one full rotation of the cell chain per column, over min(num_cols,
// MAX_DIM) columns, then a flush; an empty store or zero column count ends it early.
// Each result is held until the next match or the end of the scan, then strobes for
// one cycle; the receiver cannot stall. Reset empties the store and sets num_cols to 4.
module sparse_triplet_transpose_top
   import stt_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int MAX_DIM     = 16
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   // The column count register. The user must make writes only while the block is idle;
   // the block does not enforce this. The port can always take a beat.
   logic [CSR_W-1:0] num_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= CSR_W'(4);
      end else if (csr_valid && csr_ready) begin
         num_cols_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   // The cells form a ring. A load shifts the new triplet into the first cell
   // and moves every stored triplet one place on; during the scan the last
   // cell feeds the first, so after one full turn the chain is as it was.
   chain_ctrl_type chain;
   triplet_type    cell_q [MAX_ENTRIES];
   triplet_type    feed;

   always_comb begin
      if (chain.load) begin
         feed.row   = req_data.row;
         feed.col   = req_data.col;
         feed.value = req_data.value;
      end else begin
         feed = cell_q[MAX_ENTRIES-1];
      end
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_first
         stt_cell u_cell (
            .clock (clock),
            .chain (chain),
            .d     (feed),
            .q     (cell_q[i])
         );
      end else begin : g_rest
         stt_cell u_cell (
            .clock (clock),
            .chain (chain),
            .d     (cell_q[i-1]),
            .q     (cell_q[i])
         );
      end
   end

   // The controller watches the last cell, compares its column with the column
   // being scanned and holds each match back one place, so that the final
   // result of the run can carry the last flag.
   stt_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_DIM     (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .num_cols  (num_cols_ff),
      .head      (cell_q[MAX_ENTRIES-1]),
      .busy      (busy),
      .chain     (chain),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sim/tb_sparse_triplet_transpose_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sparse_triplet_transpose_top. It loads triplet matrices,
// predicts the transposed result stream and checks every result beat field by field.
// Depends on stt_pkg and the RTL top level only.
module tb_sparse_triplet_transpose_top;
   import stt_pkg::*;

   // Sizes of the block as instantiated below.
   localparam int STORE_DEPTH = 16;
   localparam int DIM_LIMIT   = 16;

   // Worst-case time for the block to finish a scan that emits nothing: the flush
   // overhead plus one rotation of the cell chain per column, with a little margin.
   localparam int SETTLE_CYCLES = 2 + DIM_LIMIT * STORE_DEPTH + 12;

   // The limit is many times the length of the slowest correct run, with its scans,
   // sender gaps and settling pauses.
   localparam int CYCLE_LIMIT = 400000;

   localparam int REPORT_LIMIT   = 10;
   localparam int TARGET_BEATS   = 130;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   req_type          req_data  = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data  = '0;

   sparse_triplet_transpose_top #(
      .MAX_ENTRIES (STORE_DEPTH),
      .MAX_DIM     (DIM_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 10 ns clock: high for half a period, then low.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Predictor state. This is the testbench's own copy of the triplet store, the
   // entry count, the dropped-triplet flag and the column count register.
   // ---------------------------------------------------------------------------------
   triplet_type      held [STORE_DEPTH];
   int unsigned      held_count = 0;
   logic             lost_entry = 1'b0;
   logic [CSR_W-1:0] scan_cols  = 5'd4;

   // Transposed triplets that the block owes us, oldest first.
   rsp_type transposed_due [$];

   // Run statistics.
   int failures         = 0;
   int beats_sent       = 0;
   int matrices_sent    = 0;
   int results_seen     = 0;
   int settings_written = 0;
   int cycle_count      = 0;

   // Sender idling: beats go out in bursts, with random gaps in between when enabled.
   int burst_left = 0;
   bit idle_on    = 1'b1;

   // Applies one accepted load beat to the predictor. A beat carrying a triplet is
   // stored, or dropped once the store is full. A beat marked last then scans the
   // columns in order, and within each column the store in load order, so that the
   // predicted stream is stably sorted by the original column.
   function automatic void predict_transpose(input req_type beat);
      int      limit;
      rsp_type pending;
      bit      have_pending;
      if (beat.has_entry) begin
         if (held_count < STORE_DEPTH) begin
            held[held_count].row   = beat.row;
            held[held_count].col   = beat.col;
            held[held_count].value = beat.value;
            held_count++;
         end else begin
            lost_entry = 1'b1;
         end
      end
      if (!beat.is_last) return;

      // A column count above the largest dimension is treated as that dimension.
      limit        = (int'(scan_cols) > DIM_LIMIT) ? DIM_LIMIT : int'(scan_cols);
      have_pending = 1'b0;
      pending      = '0;
      for (int v = 0; v < limit; v++) begin
         for (int k = 0; k < int'(held_count); k++) begin
            if (int'(held[k].col) == v) begin
               // Hold each match back by one so that the final one can be marked last.
               if (have_pending) transposed_due.push_back(pending);
               pending.out_row   = held[k].col;
               pending.out_col   = held[k].row;
               pending.out_value = held[k].value;
               pending.out_last  = 1'b0;
               pending.overflow  = lost_entry;
               have_pending      = 1'b1;
            end
         end
      end
      if (have_pending) begin
         pending.out_last = 1'b1;
         transposed_due.push_back(pending);
      end

      // The store empties after every scan, whether or not anything came out.
      held_count = 0;
      lost_entry = 1'b0;
   endfunction

   task automatic flag_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) $display("mismatch %0d: %s", failures, what);
   endtask

   // ---------------------------------------------------------------------------------
   // Result checking. The receiver cannot stall the block, so every strobe is a
   // result beat, taken at the rising edge that ends its cycle.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (transposed_due.size() == 0) begin
            flag_failure($sformatf("unexpected result row %0d col %0d value %0d last %0b",
                                   rsp_data.out_row, rsp_data.out_col, rsp_data.out_value,
                                   rsp_data.out_last));
         end else begin
            want = transposed_due.pop_front();
            if (rsp_data.out_row   !== want.out_row   ||
                rsp_data.out_col   !== want.out_col   ||
                rsp_data.out_value !== want.out_value ||
                rsp_data.out_last  !== want.out_last  ||
                rsp_data.overflow  !== want.overflow) begin
               flag_failure($sformatf(
                  {"expected row %0d col %0d value %0d last %0b overflow %0b, ",
                   "got row %0d col %0d value %0d last %0b overflow %0b"},
                  want.out_row, want.out_col, want.out_value, want.out_last, want.overflow,
                  rsp_data.out_row, rsp_data.out_col, rsp_data.out_value,
                  rsp_data.out_last, rsp_data.overflow));
            end
         end
      end
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped by the watchdog after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers. All of them are entered just after a rising edge and drive the
   // block's inputs with nonblocking assignments, so the block sees stable values.
   // ---------------------------------------------------------------------------------

   // Sends one load beat. Before a new burst the sender may pause; start then drops for
   // a random number of cycles. The beat is taken at the first edge with busy low, and
   // start stays high afterwards in case the next beat follows straight on.
   task automatic send_beat(input req_type beat);
      int gap;
      if (idle_on && burst_left == 0) begin
         gap   = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
      predict_transpose(beat);
      if (burst_left > 0) burst_left--;
      // Bare beats without last are ignored by the block and are not counted.
      if (beat.has_entry || beat.is_last) beats_sent++;
   endtask

   // Lets the block go idle: every predicted result has to arrive, then the longest
   // possible silent scan is waited out, since a last beat that emits nothing leaves
   // no trace for us to wait on.
   task automatic settle_block();
      int waited;
      start  <= 1'b0;
      waited = 0;
      while (transposed_due.size() != 0 && waited < 4 * SETTLE_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the column count register. Only called with the block idle.
   task automatic write_num_cols(input logic [CSR_W-1:0] setting);
      csr_valid <= 1'b1;
      csr_data  <= setting;
      do @(posedge clock); while (csr_ready !== 1'b1);
      scan_cols = setting;
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   function automatic req_type make_beat(input logic [3:0] row, input logic [3:0] col,
                                         input logic [31:0] value, input logic has_entry,
                                         input logic is_last);
      req_type beat;
      beat.row       = row;
      beat.col       = col;
      beat.value     = value;
      beat.has_entry = has_entry;
      beat.is_last   = is_last;
      return beat;
   endfunction

   // A random triplet beat. Most columns fall inside the scanned range so that the
   // bulk of the entries come back out; the rest range over every column number.
   function automatic req_type random_triplet(input int col_span);
      logic [3:0]  col;
      logic [31:0] value;
      if ($urandom_range(0, 3) != 0) col = 4'($urandom_range(0, col_span - 1));
      else                           col = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 7))
         0:       value = 32'h8000_0000;
         1:       value = 32'h7fff_ffff;
         2:       value = 32'h0000_0000;
         3:       value = 32'hffff_ffff;
         default: value = $urandom;
      endcase
      return make_beat(4'($urandom_range(0, 15)), col, value, 1'b1, 1'b0);
   endfunction

   // Matrix sizes: mostly small, now and then around or beyond the store's capacity.
   function automatic int matrix_size();
      if ($urandom_range(0, 5) == 0) return $urandom_range(15, 20);
      return $urandom_range(1, 8);
   endfunction

   // Loads one matrix of random triplets. The last beat either carries the final
   // triplet or is a bare end marker; an ignored bare beat is slipped in now and then.
   task automatic load_matrix(input int entries, input bit bare_end);
      req_type beat;
      int      span;
      span = (scan_cols == 0) ? 1 :
             ((int'(scan_cols) > DIM_LIMIT) ? DIM_LIMIT : int'(scan_cols));
      // Some matrices go out back to back with no sender gaps at all.
      idle_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < entries; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            beat           = random_triplet(span);
            beat.has_entry = 1'b0;
            send_beat(beat);
         end
         beat = random_triplet(span);
         if (k == entries - 1 && !bare_end) beat.is_last = 1'b1;
         send_beat(beat);
      end
      if (bare_end || entries == 0) begin
         beat           = random_triplet(span);
         beat.has_entry = 1'b0;
         beat.is_last   = 1'b1;
         send_beat(beat);
      end
      matrices_sent++;
   endtask

   // ---------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------

   // With the reset column count of four: the extreme row, column and value codes, a
   // column beyond the scanned range, an ignored bare beat, a last beat that carries a
   // triplet, an end marker on an empty store and a matrix whose only entry is never
   // emitted.
   task automatic test_field_extremes();
      idle_on = 1'b1;
      send_beat(make_beat(4'd0,  4'd0,  32'h8000_0000, 1'b1, 1'b0));
      send_beat(make_beat(4'd15, 4'd3,  32'h7fff_ffff, 1'b1, 1'b0));
      send_beat(make_beat(4'd15, 4'd15, 32'hffff_ffff, 1'b1, 1'b0));
      send_beat(make_beat(4'd7,  4'd2,  32'h0000_0000, 1'b1, 1'b0));
      send_beat(make_beat(4'd3,  4'd1,  32'h1234_5678, 1'b0, 1'b0));
      send_beat(make_beat(4'd0,  4'd1,  32'h0000_0001, 1'b1, 1'b1));
      send_beat(make_beat(4'd9,  4'd9,  32'h0000_0005, 1'b0, 1'b1));
      send_beat(make_beat(4'd2,  4'd12, 32'h0000_002a, 1'b1, 1'b0));
      send_beat(make_beat(4'd0,  4'd0,  32'h0000_0000, 1'b0, 1'b1));
      matrices_sent += 3;
      settle_block();
   endtask

   // Fills the store past its capacity across every column: the seventeenth triplet and
   // the one on the last beat are dropped, and every result must carry the overflow
   // flag. A small matrix afterwards shows that the flag has been cleared.
   task automatic test_store_overflow();
      write_num_cols(5'd16);
      idle_on = 1'b0;
      for (int k = 0; k <= STORE_DEPTH; k++) begin
         send_beat(make_beat(4'(15 - (k % 16)), 4'(k % 16), $urandom, 1'b1, 1'b0));
      end
      send_beat(make_beat(4'd5, 4'd5, $urandom, 1'b1, 1'b1));
      matrices_sent++;
      load_matrix(3, 1'b0);
      settle_block();
   endtask

   // The column count at zero, one, its largest legal value and above the largest
   // dimension, each with a random matrix.
   task automatic test_column_settings();
      logic [CSR_W-1:0] settings [5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
      foreach (settings[i]) begin
         write_num_cols(settings[i]);
         load_matrix(matrix_size(), $urandom_range(0, 3) == 0);
         settle_block();
      end
   endtask

   // Random matrices with the column count rewritten now and then. Matrices mostly
   // follow one another without a pause, so beats queue up behind the scan.
   task automatic test_random_matrices();
      while (beats_sent < TARGET_BEATS) begin
         if ($urandom_range(0, 3) == 0) begin
            settle_block();
            write_num_cols(5'($urandom_range(0, 31)));
         end
         load_matrix(matrix_size(), $urandom_range(0, 3) == 0);
      end
      settle_block();
   endtask

   initial begin
      // Synchronous reset, released on a rising edge.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_store_overflow();
      test_column_settings();
      test_random_matrices();

      if (transposed_due.size() != 0) begin
         flag_failure($sformatf("%0d expected results never arrived",
                                transposed_due.size()));
      end

      $display("covered %0d load beats in %0d matrices with %0d column count writes",
               beats_sent, matrices_sent, settings_written);
      $display("checked %0d transposed triplets, %0d failures", results_seen, failures);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
